// File: hw/rtl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg: shared types and constants for the resizable list engine
// Request and response payloads, request and status codes, and the control
// word that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam int WORD_W     = 32;
    localparam int IDX_W      = 11;
    localparam int GROUP_SIZE = 16;

    typedef enum logic [2:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_PUSH   = 3'd2,
        REQ_INSERT = 3'd3,
        REQ_REMOVE = 3'd4,
        REQ_RESIZE = 3'd5
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_SIZE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_NOP    = 3'd0,
        CELL_WRITE  = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_PAD    = 3'd4,
        CELL_READ   = 3'd5
    } cell_op_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic [7:0]               position;
        logic signed [WORD_W-1:0] data_word;
        logic [7:0]               target_length;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        logic [7:0]               length_now;
        logic [1:0]               status;
    } rsp_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [WORD_W-1:0] word;
    } cell_ctl_t;

endpackage

// File: hw/rtl/rle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_cell: one element of the list chain
// Holds one word; takes the broadcast word, a neighbor's word or the pad word
// according to its own index, and presents its word on a tap for reads.
// ----------------------------------------------------------------------------
module rle_cell #(
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  rle_pkg::cell_ctl_t         ctl,
    input  logic [rle_pkg::WORD_W-1:0] left_word,
    input  logic [rle_pkg::WORD_W-1:0] right_word,
    output logic [rle_pkg::WORD_W-1:0] word,
    output logic [rle_pkg::WORD_W-1:0] tap
);
    import rle_pkg::*;

    localparam logic [IDX_W-1:0] ID = IDX_W'(INDEX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [WORD_W-1:0] tap_reg;
    logic [WORD_W-1:0] tap_next;

    always_comb
    begin
        word_next = word_reg;
        tap_next  = '0;
        unique case (ctl.op)
            CELL_NOP:
            begin
                word_next = word_reg;
            end
            CELL_WRITE:
            begin
                if (ID == ctl.pos)
                begin
                    word_next = ctl.word;
                end
            end
            CELL_INSERT:
            begin
                if (ID > ctl.pos)
                begin
                    word_next = left_word;
                end
                else if (ID == ctl.pos)
                begin
                    word_next = ctl.word;
                end
            end
            CELL_REMOVE:
            begin
                if (ID >= ctl.pos)
                begin
                    word_next = right_word;
                end
            end
            CELL_PAD:
            begin
                if (ID >= ctl.lo && ID < ctl.hi)
                begin
                    word_next = ctl.word;
                end
            end
            CELL_READ:
            begin
                if (ID == ctl.pos)
                begin
                    tap_next = word_reg;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        tap_reg  <= tap_next;
    end

    assign word = word_reg;
    assign tap  = tap_reg;

endmodule

// File: hw/rtl/rle_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_gather: registered OR tree over the cell taps
// Reduces the taps in groups into registers, then ORs the group registers.
// ----------------------------------------------------------------------------
module rle_gather #(
    parameter int COUNT = 128
) (
    input  logic                                  clk,
    input  logic [COUNT-1:0][rle_pkg::WORD_W-1:0] taps,
    output logic [rle_pkg::WORD_W-1:0]            gathered
);
    import rle_pkg::*;

    localparam int NGROUP = (COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [NGROUP-1:0][WORD_W-1:0] group_reg;
    logic [NGROUP-1:0][WORD_W-1:0] group_next;

    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < COUNT)
                begin
                    group_next[g] = group_next[g] | taps[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    always_comb
    begin
        gathered = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            gathered = gathered | group_reg[g];
        end
    end

endmodule

// File: hw/rtl/resizable_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resizable_list_engine_unit: bounded list of signed words on a cell chain
// Get, set, push, insert, remove and resize; every transaction returns the
// word read, the length after it and a status.
// ----------------------------------------------------------------------------
//  channel   signals                      handshake
//  request   start, busy, req             taken when start && !busy
//  response  done, rsp                    one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data  written when valid && ready
//
//  A transaction passes from acceptance to the edge that takes its done
//  strobe through request register, execute on the chain with read tap
//  capture, grouped OR reduction and response register.
//  busy is low again in the cycle that shows done, so the next transaction
//  may be accepted alongside the strobe.
//  Reset clears the length, the control state and loads the default word
//  with all ones; cell contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module resizable_list_engine_unit #(
    parameter int CAPACITY = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rle_pkg::req_t              req,
    output logic                       done,
    output rle_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rle_pkg::WORD_W-1:0] cfg_data
);
    import rle_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] CAP_IDX  = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_GATHER = 4'b0100,
        ST_REPLY  = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    req_t               req_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [LEN_W-1:0]   length_next;
    logic [WORD_W-1:0]  default_reg;
    status_t            status_reg;
    status_t            status_next;
    logic               hit_reg;
    logic               hit_next;
    logic               miss_reg;
    logic               miss_next;
    logic               done_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    cell_ctl_t          ctl;

    logic [CAPACITY-1:0][WORD_W-1:0] cell_word;
    logic [CAPACITY-1:0][WORD_W-1:0] cell_tap;
    logic [WORD_W-1:0]               gathered;

    logic [IDX_W-1:0] pos_w;
    logic [IDX_W-1:0] len_w;
    logic [IDX_W-1:0] tgt_w;
    logic [IDX_W-1:0] len_out;
    logic             accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign pos_w     = IDX_W'(req_reg.position);
    assign len_w     = IDX_W'(length_reg);
    assign tgt_w     = IDX_W'(req_reg.target_length);

    always_comb
    begin
        ctl         = '{op: CELL_NOP, pos: pos_w, lo: len_w, hi: tgt_w,
                        word: req_reg.data_word};
        length_next = length_reg;
        status_next = STAT_OK;
        hit_next    = 1'b0;
        miss_next   = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            unique case (req_reg.req_type)
                REQ_GET:
                begin
                    ctl.op = CELL_READ;
                    if (pos_w < len_w)
                    begin
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        miss_next   = 1'b1;
                        status_next = STAT_RANGE;
                    end
                end
                REQ_SET:
                begin
                    ctl.op = CELL_WRITE;
                    if (pos_w >= len_w)
                    begin
                        if (len_w < CAP_IDX)
                        begin
                            ctl.pos     = len_w;
                            length_next = length_reg + LEN_W'(1);
                        end
                        else
                        begin
                            ctl.pos     = LAST_IDX;
                            status_next = STAT_FULL;
                        end
                    end
                end
                REQ_PUSH:
                begin
                    if (len_w < CAP_IDX)
                    begin
                        ctl.op      = CELL_WRITE;
                        ctl.pos     = len_w;
                        length_next = length_reg + LEN_W'(1);
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                end
                REQ_INSERT:
                begin
                    if (pos_w > len_w)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else if (len_w >= CAP_IDX)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctl.op      = CELL_INSERT;
                        length_next = length_reg + LEN_W'(1);
                    end
                end
                REQ_REMOVE:
                begin
                    if (pos_w < len_w)
                    begin
                        ctl.op      = CELL_REMOVE;
                        length_next = length_reg - LEN_W'(1);
                    end
                    else
                    begin
                        status_next = STAT_RANGE;
                    end
                end
                REQ_RESIZE:
                begin
                    if (tgt_w == '0 || tgt_w > CAP_IDX)
                    begin
                        status_next = STAT_SIZE;
                    end
                    else
                    begin
                        ctl.op      = CELL_PAD;
                        ctl.word    = default_reg;
                        length_next = LEN_W'(tgt_w);
                    end
                end
                default:
                begin
                    ctl.op = CELL_NOP;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_W-1:0] left_word;
            logic [WORD_W-1:0] right_word;
            if (gi == 0)
            begin : g_first
                assign left_word = '0;
            end
            else
            begin : g_left
                assign left_word = cell_word[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_word = cell_word[gi];
            end
            else
            begin : g_right
                assign right_word = cell_word[gi+1];
            end
            rle_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .left_word  (left_word),
                .right_word (right_word),
                .word       (cell_word[gi]),
                .tap        (cell_tap[gi])
            );
        end
    endgenerate

    rle_gather #(
        .COUNT (CAPACITY)
    ) u_gather (
        .clk      (clk),
        .taps     (cell_tap),
        .gathered (gathered)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC:   state_next = ST_GATHER;
            ST_GATHER: state_next = ST_REPLY;
            ST_REPLY:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign len_out = IDX_W'(length_reg);

    always_comb
    begin
        rsp_next.length_now = len_out[7:0];
        rsp_next.status     = status_reg;
        if (hit_reg)
        begin
            rsp_next.read_word = gathered;
        end
        else if (miss_reg)
        begin
            rsp_next.read_word = default_reg;
        end
        else
        begin
            rsp_next.read_word = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            length_reg  <= '0;
            default_reg <= '1;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_REPLY);
            if (state_reg == ST_EXEC)
            begin
                length_reg <= length_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                default_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            miss_reg   <= miss_next;
        end
        if (state_reg == ST_REPLY)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: hw/rtl/rle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_checker: port-level checks for the resizable list engine
// Watches the request and response ports for sequencing of transactions.
// ----------------------------------------------------------------------------
module rle_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          done,
    input  rle_pkg::rsp_t rsp
);
    import rle_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("done strobe missing four cycles after acceptance");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    a_size_keeps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_SIZE) |-> (rsp.read_word == '0))
        else $error("rejected resize returned a nonzero word");

endmodule

bind resizable_list_engine_unit rle_checker u_rle_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// File: test/rle_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_list_checker: response checker for the resizable list engine
// Watches the request, response and config channels, keeps a shadow copy of
// the list and the default word, and compares every response field by field
// with the oldest predicted response. Reports the failure count, the number
// of responses still due and the shadow list length.
// ----------------------------------------------------------------------------
module rle_list_checker #(
    parameter int CAPACITY = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  rle_pkg::req_t              req,
    input  logic                       done,
    input  rle_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [rle_pkg::WORD_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending,
    output int                         list_len
);
    import rle_pkg::*;

    logic [WORD_W-1:0] shadow_cells [CAPACITY];
    logic [WORD_W-1:0] shadow_dflt;
    int                shadow_len;
    int                err_total;
    rsp_t              due_rsp_q [$];

    function automatic rsp_t list_execute(req_t r);
        rsp_t o;
        int   i;
        int   pos;
        int   tgt;
        o        = '0;
        o.status = STAT_OK;
        pos      = r.position;
        tgt      = r.target_length;
        case (r.req_type)
            REQ_GET:
            begin
                if (pos < shadow_len)
                    o.read_word = shadow_cells[pos];
                else
                begin
                    o.read_word = shadow_dflt;
                    o.status    = STAT_RANGE;
                end
            end
            REQ_SET:
            begin
                if (pos < shadow_len)
                    shadow_cells[pos] = r.data_word;
                else if (shadow_len < CAPACITY)
                begin
                    shadow_cells[shadow_len] = r.data_word;
                    shadow_len++;
                end
                else
                begin
                    shadow_cells[CAPACITY-1] = r.data_word;
                    o.status = STAT_FULL;
                end
            end
            REQ_PUSH:
            begin
                if (shadow_len < CAPACITY)
                begin
                    shadow_cells[shadow_len] = r.data_word;
                    shadow_len++;
                end
                else
                    o.status = STAT_FULL;
            end
            REQ_INSERT:
            begin
                if (pos > shadow_len)
                    o.status = STAT_RANGE;
                else if (shadow_len >= CAPACITY)
                    o.status = STAT_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = r.data_word;
                    shadow_len++;
                end
            end
            REQ_REMOVE:
            begin
                if (pos < shadow_len)
                begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
                else
                    o.status = STAT_RANGE;
            end
            REQ_RESIZE:
            begin
                if (tgt == 0 || tgt > CAPACITY)
                    o.status = STAT_SIZE;
                else
                begin
                    for (i = shadow_len; i < tgt; i++)
                        shadow_cells[i] = shadow_dflt;
                    shadow_len = tgt;
                end
            end
            default:
            begin
            end
        endcase
        o.length_now = shadow_len[7:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            shadow_len  = 0;
            shadow_dflt = '1;
            err_total   = 0;
            due_rsp_q.delete();
            fail_count <= 0;
            pending    <= 0;
            list_len   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shadow_dflt = cfg_data;
            if (done)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    err_total++;
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.read_word !== want.read_word)
                    begin
                        $error("read_word: expected %0d, got %0d",
                               want.read_word, rsp.read_word);
                        err_total++;
                    end
                    if (rsp.length_now !== want.length_now)
                    begin
                        $error("length_now: expected %0d, got %0d",
                               want.length_now, rsp.length_now);
                        err_total++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp.status);
                        err_total++;
                    end
                end
            end
            if (start && !busy)
            begin
                want      = list_execute(req);
                due_rsp_q = {due_rsp_q, want};
            end
            fail_count <= err_total;
            pending    <= due_rsp_q.size();
            list_len   <= shadow_len;
        end
    end

endmodule

// File: test/tb_resizable_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resizable_list_engine_unit: testbench for the resizable list engine
// Drives a directed sweep of every request kind and corner case, then nine
// chunks of random requests under changing default words and sender idling.
// A separate checker predicts and compares responses; a watchdog ends a hung
// run.
// ----------------------------------------------------------------------------
module tb_resizable_list_engine_unit;
    import rle_pkg::*;

    localparam int         CAPACITY    = 128;
    localparam int         CHUNK_ITEMS = 150;
    localparam int         NUM_CHUNKS  = 9;
    localparam int         STALL_LIMIT = 1000;
    localparam int         DRAIN_WAIT  = 8;
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              done;
    rsp_t              rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                list_len;
    int                idle_pct;
    int                stall_cycles;

    resizable_list_engine_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rle_list_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .list_len   (list_len)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic req_t mk_req(logic [2:0] kind, int pos, logic [WORD_W-1:0] w,
                                    int tgt);
        req_t r;
        r.req_type      = kind;
        r.position      = pos[7:0];
        r.data_word     = w;
        r.target_length = tgt[7:0];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_req(int cur_len);
        int         sel;
        int         pos;
        int         tgt;
        logic [2:0] kind;
        sel = $urandom_range(99);
        if (sel < 18)
            kind = REQ_GET;
        else if (sel < 32)
            kind = REQ_SET;
        else if (sel < 52)
            kind = REQ_PUSH;
        else if (sel < 67)
            kind = REQ_INSERT;
        else if (sel < 83)
            kind = REQ_REMOVE;
        else if (sel < 97)
            kind = REQ_RESIZE;
        else
            kind = $urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: pos = $urandom_range(cur_len);
            6, 7:             pos = cur_len + $urandom_range(2) - (cur_len > 0 ? 1 : 0);
            default:          pos = $urandom_range(255);
        endcase
        if (pos > 255)
            pos = 255;
        case ($urandom_range(19))
            0, 1, 2:    tgt = CAPACITY;
            3, 4:       tgt = 0;
            5, 6, 7:    tgt = $urandom_range(255, CAPACITY + 1);
            8, 9:       tgt = (cur_len > 1) ? cur_len - 1 : 1;
            default:    tgt = $urandom_range(CAPACITY, 1);
        endcase
        return mk_req(kind, pos, rand_word(), tgt);
    endfunction

    task automatic send_req(req_t r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_default(logic [WORD_W-1:0] w);
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int   c;
        int   n;
        req_t r;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req          <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        idle_pct     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(mk_req(REQ_GET,    0,   32'h0,         0));
        send_req(mk_req(REQ_REMOVE, 0,   32'h0,         0));
        send_req(mk_req(REQ_INSERT, 1,   32'h1111_1111, 0));
        send_req(mk_req(REQ_INSERT, 0,   32'h1234_5678, 0));
        send_req(mk_req(REQ_PUSH,   0,   32'h7fff_ffff, 0));
        send_req(mk_req(REQ_PUSH,   0,   32'h8000_0000, 0));
        send_req(mk_req(REQ_SET,    9,   32'h0,         0));
        send_req(mk_req(REQ_SET,    0,   32'hffff_ffff, 0));
        send_req(mk_req(REQ_GET,    255, 32'h0,         0));
        send_req(mk_req(REQ_RESIZE, 0,   32'h0,         0));
        send_req(mk_req(REQ_RESIZE, 0,   32'h0,         CAPACITY + 1));
        send_req(mk_req(REQ_RESIZE, 0,   32'h0,         255));
        send_req(mk_req(REQ_RESIZE, 0,   32'h0,         CAPACITY));
        send_req(mk_req(REQ_PUSH,   0,   32'h0000_0001, 0));
        send_req(mk_req(REQ_SET,    200, 32'h0bad_cafe, 0));
        send_req(mk_req(REQ_INSERT, 128, 32'h0000_0005, 0));
        send_req(mk_req(REQ_INSERT, 129, 32'h0000_0005, 0));
        send_req(mk_req(REQ_GET,    127, 32'h0,         0));
        send_req(mk_req(REQ_REMOVE, 0,   32'h0,         0));
        send_req(mk_req(REQ_REMOVE, 127, 32'h0,         0));
        send_req(mk_req(REQ_REMOVE, 126, 32'h0,         0));
        send_req(mk_req(REQ_RESIZE, 0,   32'h0,         1));
        send_req(mk_req(REQ_INSERT, 0,   32'h5555_aaaa, 0));
        send_req(mk_req(REQ_INSERT, 2,   32'h0000_0003, 0));
        send_req(mk_req(REQ_SPARE_A, 0,  32'hffff_ffff, 255));
        send_req(mk_req(REQ_SPARE_B, 255, 32'h0,        0));
        start <= 1'b0;

        for (c = 0; c < NUM_CHUNKS; c++)
        begin
            drain();
            case (c)
                0:       write_default(32'h8000_0000);
                1:       write_default(32'h7fff_ffff);
                2:       write_default(32'h0000_0000);
                5:       write_default(32'hffff_ffff);
                default: write_default($urandom);
            endcase
            if (c < 3)
                idle_pct = 8;
            else if (c < 6)
                idle_pct = 67;
            else
                idle_pct = 0;
            n = 0;
            while (n < CHUNK_ITEMS)
            begin
                r = rand_req(list_len);
                send_req(r);
                if (r.req_type <= REQ_RESIZE)
                    n++;
            end
            start <= 1'b0;
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: resizable_list_engine_unit.f
hw/rtl/rle_pkg.sv
hw/rtl/rle_cell.sv
hw/rtl/rle_gather.sv
hw/rtl/resizable_list_engine_unit.sv
hw/rtl/rle_checker.sv
test/rle_list_checker.sv
test/tb_resizable_list_engine_unit.sv
